// ===== rtl/core/nksl_pkg.sv =====
// Shared constants, request codes and link types of the nearest-K sorted slot list.
package nksl_pkg;

    // Default list depth.
    localparam int SLOTS_DEF = 8;

    // Fixed field widths.
    localparam int ID_W   = 16;
    localparam int POS_W  = 16;
    localparam int ABS_W  = 16;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int CNT_W  = 16;

    // Packed stream widths.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Request kinds carried in tuser.
    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_X = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_Y = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_Z = 2'd3;

    // Values broadcast to every cell of the chain.
    typedef struct packed {
        logic              ins;
        logic [DIST_W-1:0] dsq;
        logic [ID_W-1:0]   id;
    } bcast_t;

    // Values one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic              gt;
        logic [ID_W-1:0]   item;
        logic [DIST_W-1:0] dsq;
    } link_t;

endpackage

// ===== rtl/core/nksl_dist.sv =====
// Squared distance unit: per-axis differences squared and registered, then summed.
module nksl_dist (
    input  logic                              clk,
    input  logic                              load,
    input  logic signed [nksl_pkg::POS_W-1:0] pos_x,
    input  logic signed [nksl_pkg::POS_W-1:0] pos_y,
    input  logic signed [nksl_pkg::POS_W-1:0] pos_z,
    input  logic signed [nksl_pkg::POS_W-1:0] cam_x,
    input  logic signed [nksl_pkg::POS_W-1:0] cam_y,
    input  logic signed [nksl_pkg::POS_W-1:0] cam_z,
    output logic        [nksl_pkg::DIST_W-1:0] dsq
);
    import nksl_pkg::*;

    logic signed [POS_W:0] dx;
    logic signed [POS_W:0] dy;
    logic signed [POS_W:0] dz;
    logic [ABS_W-1:0]      ax;
    logic [ABS_W-1:0]      ay;
    logic [ABS_W-1:0]      az;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    logic [SQ_W-1:0]       sqz_reg;

    // Differences fit in 17 bits signed; magnitudes fit in 16 bits.
    always_comb
    begin
        dx = {pos_x[POS_W-1], pos_x} - {cam_x[POS_W-1], cam_x};
        dy = {pos_y[POS_W-1], pos_y} - {cam_y[POS_W-1], cam_y};
        dz = {pos_z[POS_W-1], pos_z} - {cam_z[POS_W-1], cam_z};
        ax = dx[POS_W] ? ABS_W'(-dx) : dx[ABS_W-1:0];
        ay = dy[POS_W] ? ABS_W'(-dy) : dy[ABS_W-1:0];
        az = dz[POS_W] ? ABS_W'(-dz) : dz[ABS_W-1:0];
    end

    // One 16x16 square per axis, registered when the request is taken.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            sqz_reg <= az * az;
        end
    end

    // Sum of the three squares.
    assign dsq = DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);

endmodule

// ===== rtl/core/nksl_cell.sv =====
// One list cell: holds one ranked entry and shifts right on an insertion ahead of it.
module nksl_cell #(
    parameter int IDX = 0,
    parameter int CW  = 4,
    parameter int VW  = 3
) (
    input  logic             clk,
    input  nksl_pkg::bcast_t bcast,
    input  logic [VW-1:0]    new_view,
    input  logic [CW-1:0]    cnt,
    input  nksl_pkg::link_t  left,
    input  logic [VW-1:0]    left_view,
    output nksl_pkg::link_t  right,
    output logic [VW-1:0]    right_view,
    output logic             is_pt
);
    import nksl_pkg::*;

    logic [ID_W-1:0]   item_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [VW-1:0]     view_reg;
    logic              occ;
    logic              gt;

    // The entry is farther than the offer; ties keep the held entry ahead.
    always_comb
    begin
        occ   = CW'(IDX) < cnt;
        gt    = occ && (dist_reg > bcast.dsq);
        is_pt = (gt || (CW'(IDX) == cnt)) && !left.gt;
    end

    // Take the left neighbor's entry when it moves, or the new one at the rank.
    always_ff @(posedge clk)
    begin
        if (bcast.ins)
        begin
            if (left.gt)
            begin
                item_reg <= left.item;
                dist_reg <= left.dsq;
                view_reg <= left_view;
            end
            else if (is_pt)
            begin
                item_reg <= bcast.id;
                dist_reg <= bcast.dsq;
                view_reg <= new_view;
            end
        end
    end

    assign right.gt   = gt;
    assign right.item = item_reg;
    assign right.dsq  = dist_reg;
    assign right_view = view_reg;

endmodule

// ===== rtl/core/nearest_k_sorted_slot_list.sv =====
// Top level of the nearest-K sorted slot list: stream ports, control and the cell chain.
//
// The block keeps up to SLOTS items sorted by squared distance from the camera point,
// nearest first, in a row of cells. A request is handled as follows: in the cycle it
// is accepted the three per-axis squares are computed and registered; in the insert cycle
// the squares are summed, every cell compares its entry against the sum at once, and
// the whole row shifts right by one behind the insertion point. One result is produced
// per request (offer or clear) and sits in an output register; the insert cycle waits
// until that register has been handed on or is free, and the block takes the next
// request in the cycle after the insert cycle. Clear requests empty the list and the
// offer counter. There is no start-up sweep after reset.
module nearest_k_sorted_slot_list #(
    parameter int SLOTS = nksl_pkg::SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Request stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata fields, low bit first: item_id[15:0], item_valid[16], camera_in_front[17],
    // pos_x[33:18], pos_y[49:34], pos_z[65:50], zero padding[71:66].
    input  logic [nksl_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser fields: action[0].
    input  logic                                s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata fields, low bit first: accepted[0], insert_position[3:1], view_slot[6:4],
    // evicted[7], evicted_id[23:8], entry_count[27:24], offered_count[43:28],
    // zero padding[47:44].
    output logic [nksl_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nksl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [nksl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import nksl_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_INS  = 1'b1;

    // Configuration registers.
    logic                    enable_reg;
    logic signed [POS_W-1:0] cam_x_reg;
    logic signed [POS_W-1:0] cam_y_reg;
    logic signed [POS_W-1:0] cam_z_reg;

    // Control state.
    logic            state_reg;
    logic            state_next;
    logic [CW-1:0]   held_reg;
    logic [CW-1:0]   held_next;
    logic [CNT_W-1:0] offer_reg;
    logic [CNT_W-1:0] offer_next;
    logic            m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    // Request held for the insert cycle.
    logic            action_reg;
    logic [ID_W-1:0] id_reg;
    logic            item_valid_reg;
    logic            front_reg;

    logic            take;
    logic            step;
    logic            counted;
    logic            offer;
    logic            any_pt;
    logic            full;
    logic            ins;
    logic            evict;
    logic [IW-1:0]   rank;
    logic [IW-1:0]   pooled;
    logic [DIST_W-1:0] dsq;
    logic [IW+2:0]   rank_ext;
    logic [IW+2:0]   view_ext;
    logic [CW+3:0]   held_ext;
    logic [ID_W-1:0] evicted_id;
    bcast_t          bcast;
    link_t           lnk [SLOTS+1];
    logic [IW-1:0]   vlnk [SLOTS+1];
    logic [SLOTS-1:0] pt;

    assign cfg_ready = 1'b1;
    assign take      = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign step      = (state_reg == ST_INS) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                CFG_ENABLE:   enable_reg <= cfg_data[0];
                CFG_CAMERA_X: cam_x_reg  <= cfg_data;
                CFG_CAMERA_Y: cam_y_reg  <= cfg_data;
                CFG_CAMERA_Z: cam_z_reg  <= cfg_data;
                default:      enable_reg <= enable_reg;
            endcase
        end
    end

    // Capture of the request fields.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg     <= s_tuser;
            id_reg         <= s_tdata[15:0];
            item_valid_reg <= s_tdata[16];
            front_reg      <= s_tdata[17];
        end
    end

    nksl_dist u_dist (
        .clk   (clk),
        .load  (take),
        .pos_x (s_tdata[33:18]),
        .pos_y (s_tdata[49:34]),
        .pos_z (s_tdata[65:50]),
        .cam_x (cam_x_reg),
        .cam_y (cam_y_reg),
        .cam_z (cam_z_reg),
        .dsq   (dsq)
    );

    // Cell chain; the left end sees an entry that never moves.
    assign lnk[0]  = '0;
    assign vlnk[0] = '0;
    assign bcast.ins  = ins;
    assign bcast.dsq  = dsq;
    assign bcast.id   = id_reg;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        nksl_cell #(
            .IDX (i),
            .CW  (CW),
            .VW  (IW)
        ) u_cell (
            .clk        (clk),
            .bcast      (bcast),
            .new_view   (pooled),
            .cnt        (held_reg),
            .left       (lnk[i]),
            .left_view  (vlnk[i]),
            .right      (lnk[i+1]),
            .right_view (vlnk[i+1]),
            .is_pt      (pt[i])
        );
    end

    // Rank of the insertion point; at most one cell reports it.
    always_comb
    begin
        rank = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pt[i])
            begin
                rank = rank | IW'(i);
            end
        end
    end

    // Decision for the request in the insert cycle.
    always_comb
    begin
        any_pt     = |pt;
        full       = (held_reg == CW'(SLOTS));
        counted    = (action_reg == ACT_OFFER) && enable_reg && item_valid_reg;
        offer      = counted && front_reg;
        ins        = step && offer && any_pt;
        evict      = offer && any_pt && full;
        pooled     = full ? vlnk[SLOTS] : held_reg[IW-1:0];
        evicted_id = evict ? lnk[SLOTS].item : '0;

        held_next  = held_reg;
        offer_next = offer_reg;
        if (action_reg == ACT_CLEAR)
        begin
            held_next  = '0;
            offer_next = '0;
        end
        else
        begin
            if (counted)
            begin
                offer_next = offer_reg + 1'b1;
            end
            if (offer && any_pt && !full)
            begin
                held_next = held_reg + 1'b1;
            end
        end

        rank_ext = (offer && any_pt) ? {3'b000, rank} : '0;
        view_ext = (offer && any_pt) ? {3'b000, pooled} : '0;
        held_ext = {4'b0000, held_next};

        m_tdata_next        = '0;
        m_tdata_next[0]     = offer && any_pt;
        m_tdata_next[3:1]   = rank_ext[2:0];
        m_tdata_next[6:4]   = view_ext[2:0];
        m_tdata_next[7]     = evict;
        m_tdata_next[23:8]  = evicted_id;
        m_tdata_next[27:24] = held_ext[3:0];
        m_tdata_next[43:28] = offer_next;
    end

    // Sequencer and list counters.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (take) state_next = ST_INS;
            ST_INS:  if (step) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            offer_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (step)
            begin
                held_reg  <= held_next;
                offer_reg <= offer_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (step)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule
